[hw/rtl/score_threshold_error_rates_core_macros.svh]
// assertion macros shared by the score threshold error rates core
`ifndef SCORE_THRESHOLD_ERROR_RATES_CORE_MACROS_SVH
`define SCORE_THRESHOLD_ERROR_RATES_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while reset is held
`define STRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, off while reset is held
`define STRE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// condition that must never hold
`define STRE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define STRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define STRE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`define STRE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/stre_pkg.sv]
// shared types, widths, codes and helpers of the score threshold error rates core
package stre_pkg;

    // counter and field widths
    localparam int CNT_W    = 20;
    localparam logic [CNT_W-1:0] MAX_COUNT = 20'hFFFFF;
    localparam int SCORE_W  = 32;
    localparam int BETA_W   = 16;
    localparam int RATE_W   = 17;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 16;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA      = 8'd1;
    localparam logic [SCORE_W-1:0]     THRESHOLD_RST = 32'd0;
    localparam logic [BETA_W-1:0]      BETA_RST      = 16'd256;
    localparam logic [BETA_W-1:0]      BETA_ONE      = 16'd256;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_NEG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_POS = 2'd2;

    // arithmetic unit widths
    localparam int NUM_W     = 64;   // dividend and product width
    localparam int DEN_W     = 49;   // divisor width
    localparam int SQ_W      = 32;   // beta squared
    localparam int DIV_CNT_W = 6;    // one step per dividend bit
    localparam int MUL_STEPS = 17;   // one step per multiplier bit
    localparam int MUL_CNT_W = 5;
    localparam logic [SQ_W-1:0] ONE_Q16 = 32'h0001_0000;

    // queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // one finished batch as handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]  neg_total;
        logic [CNT_W-1:0]  pos_total;
        logic [CNT_W-1:0]  neg_acc;
        logic [CNT_W-1:0]  pos_acc;
        logic [BETA_W-1:0] beta;
    } t_batch;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == MAX_COUNT) ? c : c + 1'b1;
    endfunction

endpackage

[hw/rtl/score_threshold_error_rates_core.sv]
// top level of the score threshold error rates core
//
// Usage: scores enter on the input channel (i_valid / o_ready) with i_score,
// i_is_positive and i_last; one word can be taken every cycle unless the queue
// is full. Each score is compared against the threshold (at or above counts as
// accepted) and four saturating counters are updated. The word with i_last high
// closes the batch: its counts are queued and the counters restart at zero on
// the next cycle. Each batch gives one result word on the output channel
// (o_valid / i_ready): FAR, FRR, precision, recall and F-beta as Q1.16 fractions
// plus a status. A result takes at most five divisions (64-step bit-serial divider)
// and four shift-add products (17 steps); an empty-class batch skips them. The back
// end takes a new batch only once the last result word is loaded, and the queue
// holds two finished batches; o_ready drops only while the queue is full, after
// short batches outpace the back end or while the receiver stalls the result
// word. Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
// threshold (index 0) and the F-score weight beta (index 1); the user must write
// them only while idle, as the block does not enforce it. Synchronous active-low
// reset clears counters, queue and result valid and restores threshold 0 and
// beta 1.0.
module score_threshold_error_rates_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // score channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [stre_pkg::SCORE_W-1:0]       i_score,
    input  logic                               i_is_positive,
    input  logic                               i_last,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [stre_pkg::RATE_W-1:0]        o_false_accept_rate,
    output logic [stre_pkg::RATE_W-1:0]        o_false_reject_rate,
    output logic [stre_pkg::RATE_W-1:0]        o_precision,
    output logic [stre_pkg::RATE_W-1:0]        o_recall,
    output logic [stre_pkg::RATE_W-1:0]        o_f_beta,
    output logic [stre_pkg::STATUS_W-1:0]      o_status,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stre_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [stre_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import stre_pkg::*;

    logic [SCORE_W-1:0] r_threshold;
    logic [BETA_W-1:0]  r_beta;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;
    t_batch             front_batch;
    t_batch             head_batch;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_beta      <= BETA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_BETA:      r_beta      <= i_cfg_data[BETA_W-1:0];
                default:       r_beta      <= r_beta;
            endcase
        end
    end

    // counting front end
    stre_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_score       (i_score),
        .i_is_positive (i_is_positive),
        .i_last        (i_last),
        .i_threshold   (r_threshold),
        .i_beta        (r_beta),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_batch       (front_batch)
    );

    // batch queue
    stre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_batch (front_batch),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_batch (head_batch),
        .i_pop   (q_pop)
    );

    // rate back end
    stre_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_batch           (head_batch),
        .o_pop               (q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_false_accept_rate (o_false_accept_rate),
        .o_false_reject_rate (o_false_reject_rate),
        .o_precision         (o_precision),
        .o_recall            (o_recall),
        .o_f_beta            (o_f_beta),
        .o_status            (o_status)
    );

endmodule

[hw/rtl/stre_queue.sv]
// two-entry batch queue between the counting front and the rate back end
`include "score_threshold_error_rates_core_macros.svh"
module stre_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stre_pkg::t_batch  i_batch,
    output logic              o_full,
    output logic              o_valid,
    output stre_pkg::t_batch  o_batch,
    input  logic              i_pop
);
    import stre_pkg::*;

    t_batch              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    // occupancy flags
    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_batch = r_mem[r_rd_ptr];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_batch;
        end
    end

    `STRE_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `STRE_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

[hw/rtl/stre_div.sv]
// bit-serial restoring divider, one dividend bit per cycle
module stre_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stre_pkg::NUM_W-1:0]    i_num,
    input  logic [stre_pkg::DEN_W-1:0]    i_den,
    output stre_pkg::t_div_stat           o_stat,
    output logic [stre_pkg::RATE_W-1:0]   o_quo
);
    import stre_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 q_bit;

    // one compare and subtract step
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == DIV_CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo[RATE_W-1:0];

endmodule

[hw/rtl/stre_front.sv]
// front end: threshold compare, saturating class counters, batch hand-off
module stre_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [stre_pkg::SCORE_W-1:0]   i_score,
    input  logic                           i_is_positive,
    input  logic                           i_last,
    input  logic [stre_pkg::SCORE_W-1:0]   i_threshold,
    input  logic [stre_pkg::BETA_W-1:0]    i_beta,
    input  logic                           i_q_full,
    output logic                           o_push,
    output stre_pkg::t_batch               o_batch
);
    import stre_pkg::*;

    logic [CNT_W-1:0] r_neg_total, n_neg_total;
    logic [CNT_W-1:0] r_pos_total, n_pos_total;
    logic [CNT_W-1:0] r_neg_acc,   n_neg_acc;
    logic [CNT_W-1:0] r_pos_acc,   n_pos_acc;
    logic             accepted;
    logic             take;

    // a word is taken whenever the queue can hold a finished batch
    assign o_ready  = !i_q_full;
    assign take     = i_valid && o_ready;
    assign accepted = ($signed(i_score) >= $signed(i_threshold));

    // counters including the current word
    always_comb begin
        n_neg_total = r_neg_total;
        n_pos_total = r_pos_total;
        n_neg_acc   = r_neg_acc;
        n_pos_acc   = r_pos_acc;
        if (i_is_positive) begin
            n_pos_total = sat_inc(r_pos_total);
            if (accepted) begin
                n_pos_acc = sat_inc(r_pos_acc);
            end
        end else begin
            n_neg_total = sat_inc(r_neg_total);
            if (accepted) begin
                n_neg_acc = sat_inc(r_neg_acc);
            end
        end
    end

    // counter registers, cleared after the last word of a batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_total <= '0;
            r_pos_total <= '0;
            r_neg_acc   <= '0;
            r_pos_acc   <= '0;
        end else if (take) begin
            if (i_last) begin
                r_neg_total <= '0;
                r_pos_total <= '0;
                r_neg_acc   <= '0;
                r_pos_acc   <= '0;
            end else begin
                r_neg_total <= n_neg_total;
                r_pos_total <= n_pos_total;
                r_neg_acc   <= n_neg_acc;
                r_pos_acc   <= n_pos_acc;
            end
        end
    end

    // batch snapshot toward the queue
    assign o_push            = take && i_last;
    assign o_batch.neg_total = n_neg_total;
    assign o_batch.pos_total = n_pos_total;
    assign o_batch.neg_acc   = n_neg_acc;
    assign o_batch.pos_acc   = n_pos_acc;
    assign o_batch.beta      = i_beta;

endmodule

[hw/rtl/stre_back.sv]
// back end: sequencer over a shared divider and shift-add multiplier, result register
`include "score_threshold_error_rates_core_macros.svh"
module stre_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  stre_pkg::t_batch                i_q_batch,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [stre_pkg::RATE_W-1:0]     o_false_accept_rate,
    output logic [stre_pkg::RATE_W-1:0]     o_false_reject_rate,
    output logic [stre_pkg::RATE_W-1:0]     o_precision,
    output logic [stre_pkg::RATE_W-1:0]     o_recall,
    output logic [stre_pkg::RATE_W-1:0]     o_f_beta,
    output logic [stre_pkg::STATUS_W-1:0]   o_status
);
    import stre_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DIV_FAR  = 11'b000_0000_0010,
        S_DIV_FRR  = 11'b000_0000_0100,
        S_DIV_PREC = 11'b000_0000_1000,
        S_DIV_REC  = 11'b000_0001_0000,
        S_MUL_B2   = 11'b000_0010_0000,
        S_MUL_T1   = 11'b000_0100_0000,
        S_MUL_N1   = 11'b000_1000_0000,
        S_MUL_N2   = 11'b001_0000_0000,
        S_DIV_FB   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state              r_state;
    logic                r_started;
    t_batch              r_b;
    logic [STATUS_W-1:0] r_status;
    logic [RATE_W-1:0]   r_far, r_frr, r_prec, r_rec, r_fb;
    logic [SQ_W-1:0]     r_b2;
    logic [DEN_W-1:0]    r_t1;
    logic [DEN_W-1:0]    r_n1;
    logic [NUM_W-1:0]    r_num;

    // multiplier
    logic                 r_mul_busy;
    logic                 r_mul_done;
    logic [MUL_CNT_W-1:0] r_mcnt;
    logic [NUM_W-1:0]     r_mc;
    logic [RATE_W-1:0]    r_mb;
    logic [NUM_W-1:0]     r_acc;
    logic [NUM_W-1:0]     n_acc;

    // result register
    logic                r_o_valid;
    logic [RATE_W-1:0]   r_out_far, r_out_frr, r_out_prec, r_out_rec, r_out_fb;
    logic [STATUS_W-1:0] r_out_status;

    logic                is_div;
    logic                is_mul;
    logic                div_start;
    logic                mul_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [NUM_W-1:0]    mul_mc;
    logic [RATE_W-1:0]   mul_mb;
    t_div_stat           div_stat;
    logic [RATE_W-1:0]   div_quo;
    logic [STATUS_W-1:0] q_status;
    logic [CNT_W:0]      acc_sum;
    logic [BETA_W-1:0]   beta_eff;
    logic                load_out;

    // divider instance
    stre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // status of the batch at the queue head
    assign q_status = ((i_q_batch.neg_total == '0) ? ST_NO_NEG : ST_OK)
                    | ((i_q_batch.pos_total == '0) ? ST_NO_POS : ST_OK);

    assign is_div = (r_state == S_DIV_FAR) || (r_state == S_DIV_FRR)
                 || (r_state == S_DIV_PREC) || (r_state == S_DIV_REC)
                 || (r_state == S_DIV_FB);
    assign is_mul = (r_state == S_MUL_B2) || (r_state == S_MUL_T1)
                 || (r_state == S_MUL_N1) || (r_state == S_MUL_N2);
    assign div_start = is_div && !r_started;
    assign mul_start = is_mul && !r_started;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign load_out  = (r_state == S_DONE) && (!r_o_valid || i_ready);

    assign acc_sum  = {1'b0, r_b.pos_acc} + {1'b0, r_b.neg_acc};
    assign beta_eff = (r_b.beta == '0) ? BETA_ONE : r_b.beta;

    // operand selection for the shared units
    always_comb begin
        div_num = '0;
        div_den = '0;
        mul_mc  = '0;
        mul_mb  = '0;
        case (r_state)
            S_DIV_FAR: begin
                div_num = {28'd0, r_b.neg_acc, 16'd0};
                div_den = {29'd0, r_b.neg_total};
            end
            S_DIV_FRR: begin
                div_num = {28'd0, r_b.pos_total - r_b.pos_acc, 16'd0};
                div_den = {29'd0, r_b.pos_total};
            end
            S_DIV_PREC: begin
                div_num = {28'd0, r_b.pos_acc, 16'd0};
                div_den = (acc_sum == '0) ? DEN_W'(1) : {28'd0, acc_sum};
            end
            S_DIV_REC: begin
                div_num = {28'd0, r_b.pos_acc, 16'd0};
                div_den = {29'd0, r_b.pos_total};
            end
            S_MUL_B2: begin
                mul_mc = {48'd0, beta_eff};
                mul_mb = {1'b0, beta_eff};
            end
            S_MUL_T1: begin
                mul_mc = {32'd0, r_b2};
                mul_mb = r_prec;
            end
            S_MUL_N1: begin
                mul_mc = {32'd0, r_b2 + ONE_Q16};
                mul_mb = r_prec;
            end
            S_MUL_N2: begin
                mul_mc = {15'd0, r_n1};
                mul_mb = r_rec;
            end
            S_DIV_FB: begin
                div_num = r_num;
                div_den = r_t1 + {16'd0, r_rec, 16'd0};
            end
            default: begin
                div_num = '0;
            end
        endcase
    end

    // shift-add multiplier, one multiplier bit per cycle
    assign n_acc = r_acc + (r_mb[0] ? r_mc : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_done <= 1'b0;
            r_mcnt     <= '0;
        end else begin
            r_mul_done <= r_mul_busy && !mul_start && (r_mcnt == MUL_CNT_W'(MUL_STEPS - 1));
            if (mul_start) begin
                r_mul_busy <= 1'b1;
                r_mcnt     <= '0;
            end else if (r_mul_busy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_mul_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mc  <= mul_mc;
            r_mb  <= mul_mb;
            r_acc <= '0;
        end else if (r_mul_busy) begin
            r_mc  <= {r_mc[NUM_W-2:0], 1'b0};
            r_mb  <= {1'b0, r_mb[RATE_W-1:1]};
            r_acc <= n_acc;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // result word held until taken
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if ((is_div || is_mul) && !r_started) begin
                r_started <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_b      <= i_q_batch;
                        r_status <= q_status;
                        if (q_status != ST_OK) begin
                            r_far   <= '0;
                            r_frr   <= '0;
                            r_prec  <= '0;
                            r_rec   <= '0;
                            r_fb    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV_FAR;
                        end
                    end
                end
                S_DIV_FAR: begin
                    if (r_started && div_stat.done) begin
                        r_started <= 1'b0;
                        r_far     <= div_quo;
                        r_state   <= S_DIV_FRR;
                    end
                end
                S_DIV_FRR: begin
                    if (r_started && div_stat.done) begin
                        r_started <= 1'b0;
                        r_frr     <= div_quo;
                        r_state   <= S_DIV_PREC;
                    end
                end
                S_DIV_PREC: begin
                    if (r_started && div_stat.done) begin
                        r_started <= 1'b0;
                        r_prec    <= div_quo;
                        r_state   <= S_DIV_REC;
                    end
                end
                S_DIV_REC: begin
                    if (r_started && div_stat.done) begin
                        r_started <= 1'b0;
                        r_rec     <= div_quo;
                        // both zero: f-score is zero, skip the products
                        if (r_prec == '0 && div_quo == '0) begin
                            r_fb    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL_B2;
                        end
                    end
                end
                S_MUL_B2: begin
                    if (r_started && r_mul_done) begin
                        r_started <= 1'b0;
                        r_b2      <= r_acc[SQ_W-1:0];
                        r_state   <= S_MUL_T1;
                    end
                end
                S_MUL_T1: begin
                    if (r_started && r_mul_done) begin
                        r_started <= 1'b0;
                        r_t1      <= r_acc[DEN_W-1:0];
                        r_state   <= S_MUL_N1;
                    end
                end
                S_MUL_N1: begin
                    if (r_started && r_mul_done) begin
                        r_started <= 1'b0;
                        r_n1      <= r_acc[DEN_W-1:0];
                        r_state   <= S_MUL_N2;
                    end
                end
                S_MUL_N2: begin
                    if (r_started && r_mul_done) begin
                        r_started <= 1'b0;
                        r_num     <= r_acc;
                        r_state   <= S_DIV_FB;
                    end
                end
                S_DIV_FB: begin
                    if (r_started && div_stat.done) begin
                        r_started <= 1'b0;
                        r_fb      <= div_quo;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_far    <= r_far;
            r_out_frr    <= r_frr;
            r_out_prec   <= r_prec;
            r_out_rec    <= r_rec;
            r_out_fb     <= r_fb;
            r_out_status <= r_status;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_false_accept_rate = r_out_far;
    assign o_false_reject_rate = r_out_frr;
    assign o_precision         = r_out_prec;
    assign o_recall            = r_out_rec;
    assign o_f_beta            = r_out_fb;
    assign o_status            = r_out_status;

    `STRE_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_stat.done, is_div,
        "divider finished outside a divide step")
    `STRE_ASSERT_NEVER(a_units_exclusive, i_clk, i_rst_n, r_mul_busy && div_stat.busy,
        "multiplier and divider busy together")
    `STRE_ASSERT_NXT(a_empty_class_zero, i_clk, i_rst_n, load_out && (r_status != ST_OK),
        (o_f_beta == '0) && (o_precision == '0) && (o_false_accept_rate == '0),
        "empty class result not zero")

endmodule

[dv/tb.sv]
// self-checking testbench of the score threshold error rates core
`timescale 1ns / 1ps

module tb;
    import stre_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 450;    // a little over the result latency
    localparam int STALL_LIMIT   = 20000;  // cycles with no handshake at all
    localparam int LONG_HOLD     = 1200;
    localparam int IDLE_PCT      = 12;
    localparam int RANDOM_ITEMS  = 660;
    localparam int PHASES        = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TOP   = 8'hFF;
    localparam logic [STATUS_W-1:0]    ST_NO_BOTH    = ST_NO_NEG | ST_NO_POS;
    localparam logic [SCORE_W-1:0]     SCORE_MIN     = 32'h8000_0000;
    localparam logic [SCORE_W-1:0]     SCORE_MAX     = 32'h7FFF_FFFF;

    // one expected result word
    typedef struct {
        logic [RATE_W-1:0]   far;
        logic [RATE_W-1:0]   frr;
        logic [RATE_W-1:0]   prec;
        logic [RATE_W-1:0]   rec;
        logic [RATE_W-1:0]   fbeta;
        logic [STATUS_W-1:0] status;
    } rate_word_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [SCORE_W-1:0]     i_score = '0;
    logic                   i_is_positive = 1'b0;
    logic                   i_last = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [RATE_W-1:0]      o_false_accept_rate;
    logic [RATE_W-1:0]      o_false_reject_rate;
    logic [RATE_W-1:0]      o_precision;
    logic [RATE_W-1:0]      o_recall;
    logic [RATE_W-1:0]      o_f_beta;
    logic [STATUS_W-1:0]    o_status;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor copy of registers and counters
    logic [SCORE_W-1:0] thr_q16 = THRESHOLD_RST;
    logic [BETA_W-1:0]  beta_q8 = BETA_RST;
    logic [CNT_W-1:0]   neg_total = '0;
    logic [CNT_W-1:0]   pos_total = '0;
    logic [CNT_W-1:0]   neg_acc = '0;
    logic [CNT_W-1:0]   pos_acc = '0;
    rate_word_t         pending_rates[$];
    rate_word_t         oldest_rate;

    // run control and statistics
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned scores_sent = 0;
    int unsigned batches_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;

    score_threshold_error_rates_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_score             (i_score),
        .i_is_positive       (i_is_positive),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_false_accept_rate (o_false_accept_rate),
        .o_false_reject_rate (o_false_reject_rate),
        .o_precision         (o_precision),
        .o_recall            (o_recall),
        .o_f_beta            (o_f_beta),
        .o_status            (o_status),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result receiver: random idling and long hold-offs on request
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            i_ready = 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_idle_en) begin
            i_ready = ($urandom_range(99) >= IDLE_PCT);
        end else begin
            i_ready = 1'b1;
        end
    end

    // watchdog and back-pressure count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (i_rst_n && i_valid && o_ready !== 1'b1)
            backpressure_cycles = backpressure_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("score_threshold_error_rates_core regression: fail");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_rates.size() == 0) begin
                $display("%0t ns: result word with nothing expected, expected none, actual %0d",
                         $time, o_status);
                fail_count++;
            end else begin
                oldest_rate = pending_rates.pop_front();
                check_field("false_accept_rate", oldest_rate.far, o_false_accept_rate);
                check_field("false_reject_rate", oldest_rate.frr, o_false_reject_rate);
                check_field("precision", oldest_rate.prec, o_precision);
                check_field("recall", oldest_rate.rec, o_recall);
                check_field("f_beta", oldest_rate.fbeta, o_f_beta);
                check_field("status", RATE_W'(oldest_rate.status), RATE_W'(o_status));
                results_seen++;
            end
        end
    end

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
        return (c >= MAX_COUNT) ? MAX_COUNT : c + 1'b1;
    endfunction

    // truncating Q1.16 fraction, zero divisor taken as one
    function automatic logic [RATE_W-1:0] q16_ratio(input bit [63:0] num, input bit [63:0] den);
        bit [63:0] q;
        if (den == 0)
            den = 64'd1;
        q = (num << FRAC_W) / den;
        return q[RATE_W-1:0];
    endfunction

    // f-beta from Q1.16 precision and recall, beta in Q8.8
    function automatic logic [RATE_W-1:0] weighted_f(input bit [63:0] p, input bit [63:0] r,
                                                     input logic [BETA_W-1:0] beta);
        bit [63:0] b;
        bit [63:0] b2;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        b = (beta == 0) ? 64'(BETA_ONE) : 64'(beta);
        b2 = b * b;
        if (p == 0 && r == 0)
            return '0;
        num = (64'(ONE_Q16) + b2) * p * r;
        den = b2 * p + 64'(ONE_Q16) * r;
        if (den == 0)
            return '0;
        q = num / den;
        return q[RATE_W-1:0];
    endfunction

    // count one accepted score and, on the last one, queue the expected rates
    task automatic tally_score(input logic [SCORE_W-1:0] s, input logic pos, input logic lst);
        logic       hit;
        bit [63:0]  ntot;
        bit [63:0]  ptot;
        bit [63:0]  nacc;
        bit [63:0]  pacc;
        rate_word_t w;
        hit = $signed(s) >= $signed(thr_q16);
        scores_sent++;
        if (pos) begin
            pos_total = bump_count(pos_total);
            if (hit)
                pos_acc = bump_count(pos_acc);
        end else begin
            neg_total = bump_count(neg_total);
            if (hit)
                neg_acc = bump_count(neg_acc);
        end
        if (lst) begin
            ntot = 64'(neg_total);
            ptot = 64'(pos_total);
            nacc = 64'(neg_acc);
            pacc = 64'(pos_acc);
            w = '{far: '0, frr: '0, prec: '0, rec: '0, fbeta: '0, status: ST_OK};
            if (ntot == 0)
                w.status = w.status | ST_NO_NEG;
            if (ptot == 0)
                w.status = w.status | ST_NO_POS;
            if (w.status == ST_OK) begin
                w.far = q16_ratio(nacc, ntot);
                w.frr = q16_ratio(ptot - pacc, ptot);
                w.prec = q16_ratio(pacc, pacc + nacc);
                w.rec = q16_ratio(pacc, ptot);
                w.fbeta = weighted_f(64'(w.prec), 64'(w.rec), beta_q8);
            end
            pending_rates.push_back(w);
            batches_sent++;
            neg_total = '0;
            pos_total = '0;
            neg_acc = '0;
            pos_acc = '0;
        end
    endtask

    // offer one score word and wait until it is taken
    task automatic put_score(input logic [SCORE_W-1:0] s, input logic pos, input logic lst);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_score = s;
        i_is_positive = pos;
        i_last = lst;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        tally_score(s, pos, lst);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_THRESHOLD: thr_q16 = data;
            CFG_BETA:      beta_q8 = data[BETA_W-1:0];
            default:       ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop sending, wait for every expected word, then let the core go quiet
    task automatic settle_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_rates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // two in five near the threshold, one in ten extremes, rest anywhere
    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return thr_q16 + $urandom_range(8) - 4;
        if (r < 50) begin
            case ($urandom_range(3))
                0:       return SCORE_MIN;
                1:       return SCORE_MAX;
                2:       return thr_q16;
                default: return thr_q16 - 1;
            endcase
        end
        return $urandom;
    endfunction

    // whole batches of random length and class mix
    task automatic random_batches(input int n_items, input int max_len);
        int sent;
        int len;
        int mode;
        int r;
        logic pos;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 80)
                len = $urandom_range(1, 12);
            else if (r < 95)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 200);
            if (len > max_len)
                len = max_len;
            mode = $urandom_range(99);
            for (int k = 0; k < len; k++) begin
                if (mode < 15)
                    pos = 1'b1;
                else if (mode < 30)
                    pos = 1'b0;
                else
                    pos = 1'($urandom_range(1));
                put_score(pick_score(), pos, k == len - 1);
            end
            sent += len;
        end
    endtask

    // reset values: equal-to-threshold accepted, signed extremes
    task automatic test_default_config();
        put_score(32'd0, 1'b0, 1'b0);
        put_score(32'hFFFF_FFFF, 1'b0, 1'b0);
        put_score(SCORE_MAX, 1'b1, 1'b0);
        put_score(SCORE_MIN, 1'b1, 1'b1);
    endtask

    // one-class batches and a batch where nothing is accepted
    task automatic test_class_cases();
        put_score(32'd123, 1'b1, 1'b1);
        put_score(-32'sd5, 1'b0, 1'b1);
        put_score(32'hFFFF_FFFF, 1'b0, 1'b0);
        put_score(32'hFFFF_FFFE, 1'b1, 1'b1);
    endtask

    // lowest and highest threshold, zero and full weight
    task automatic test_register_extremes();
        settle_block();
        write_reg(CFG_THRESHOLD, SCORE_MIN);
        write_reg(CFG_BETA, 32'd0);
        put_score(SCORE_MIN, 1'b0, 1'b0);
        put_score(32'd1, 1'b1, 1'b0);
        put_score(SCORE_MAX, 1'b1, 1'b1);
        settle_block();
        write_reg(CFG_THRESHOLD, SCORE_MAX);
        write_reg(CFG_BETA, 32'h0000_FFFF);
        put_score(SCORE_MAX, 1'b0, 1'b0);
        put_score(SCORE_MAX - 1, 1'b0, 1'b0);
        put_score(SCORE_MAX, 1'b1, 1'b0);
        put_score(32'd0, 1'b1, 1'b1);
    endtask

    // writes to unused indexes leave both registers alone
    task automatic test_ignored_index();
        settle_block();
        write_reg(CFG_THRESHOLD, 32'h0001_0000);
        write_reg(CFG_BETA, 32'd512);
        write_reg(CFG_IDX_SPARE, SCORE_MAX);
        write_reg(CFG_IDX_TOP, 32'hFFFF_FFFF);
        put_score(32'h0001_0000, 1'b0, 1'b0);
        put_score(32'h0000_FFFF, 1'b0, 1'b0);
        put_score(32'h0001_0000, 1'b1, 1'b1);
    endtask

    // receiver holds off while short batches keep coming and fill the queue
    task automatic test_backpressure();
        settle_block();
        write_reg(CFG_THRESHOLD, $urandom_range(32'h0002_0000) - 32'h0001_0000);
        write_reg(CFG_BETA, $urandom_range(1, 1024));
        rx_hold_req = LONG_HOLD;
        random_batches(120, 4);
    endtask

    // several register settings, extremes among them, with random batches
    task automatic test_random_sweep();
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            case (ph)
                0: begin
                    write_reg(CFG_THRESHOLD, THRESHOLD_RST);
                    write_reg(CFG_BETA, BETA_ONE);
                end
                1: begin
                    write_reg(CFG_THRESHOLD, $urandom);
                    write_reg(CFG_BETA, $urandom);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, SCORE_MIN);
                    write_reg(CFG_BETA, 32'd0);
                end
                3: begin
                    write_reg(CFG_THRESHOLD, SCORE_MAX);
                    write_reg(CFG_BETA, 32'hFFFF_FFFF);
                end
                4: begin
                    write_reg(CFG_THRESHOLD, $urandom_range(32'h0010_0000) - 32'h0008_0000);
                    write_reg(CFG_BETA, $urandom_range(1, 512));
                end
                default: begin
                    write_reg(CFG_THRESHOLD, $urandom);
                    write_reg(CFG_BETA, $urandom_range(65535));
                end
            endcase
            // one phase without any idling on either side
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);
            if (ph == 2) begin
                // sender pauses halfway until everything is back
                random_batches(RANDOM_ITEMS / (2 * PHASES), 200);
                settle_block();
                random_batches(RANDOM_ITEMS / (2 * PHASES), 200);
            end else begin
                random_batches(RANDOM_ITEMS / PHASES, 200);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // reset, tests in turn, drain and verdict
    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_config();
        test_class_cases();
        test_register_extremes();
        test_ignored_index();
        test_backpressure();
        test_random_sweep();

        settle_block();
        if (pending_rates.size() != 0) begin
            $display("%0t ns: results never arrived, expected 0 left, actual %0d",
                     $time, pending_rates.size());
            fail_count++;
        end
        $display("covered %0d scores in %0d batches with %0d register writes",
                 scores_sent, batches_sent, cfg_writes);
        $display("checked %0d result words, input stalled for %0d cycles, %0d mismatches",
                 results_seen, backpressure_cycles, fail_count);
        if (fail_count == 0)
            $display("score_threshold_error_rates_core regression: pass");
        else
            $display("score_threshold_error_rates_core regression: fail");
        $finish;
    end

endmodule
